// ===== rtl/aae_pkg.sv =====
// Package for the adaptive arithmetic encoder.
// Holds the shared types, codes and constants; no dependencies.
`timescale 1ns / 1ps

package aae_pkg;

  localparam int CODE_W = 16;
  localparam int CNT_W  = 14;
  localparam int PEND_W = 9;
  localparam int SPAN_W = 17;
  localparam int PROD_W = SPAN_W + CNT_W;
  localparam int GUARD_W = 5;

  localparam logic [CODE_W-1:0] QTR1 = 16'h4000;
  localparam logic [CODE_W-1:0] QTR2 = 16'h8000;
  localparam logic [CODE_W-1:0] QTR3 = 16'hc000;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 14'h3fff;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       finish;
    logic [7:0] symbol;
  } op_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_DRY,
    S_REAL,
    S_PUTBIT,
    S_PUTPEND,
    S_FIN,
    S_FLUSH,
    S_UPD_SETUP,
    S_UPD_RD,
    S_UPD_WR,
    S_DONE
  } back_state_e;

  typedef enum logic [1:0] {
    RN_NONE,
    RN_ZERO,
    RN_ONE,
    RN_MID
  } renorm_e;

endpackage

// ===== rtl/aae_if.sv =====
// Handshake channel interfaces of the adaptive arithmetic encoder.
// Depends on nothing; used by the top level, the front end and the back end.
`timescale 1ns / 1ps

interface aae_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] symbol;
  modport source (output valid, command, symbol, input ready);
  modport sink (input valid, command, symbol, output ready);
endinterface

interface aae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       pending_saturated;
  modport source (output valid, out_byte, last, pending_saturated, input ready);
  modport sink (input valid, out_byte, last, pending_saturated, output ready);
endinterface

// ===== rtl/adaptive_arithmetic_encoder.sv =====
// Adaptive arithmetic encoder with a 16-bit code range over a byte alphabet.
// Encode transactions pass through a two-entry queue into a back end that
// narrows the interval with a shared divider resolving one quotient bit per
// cycle. It runs twice per symbol, each use preceded by the multiply and the
// start. A trial pass over the renormalization then fixes the saturation flag
// before any byte leaves. The real pass shifts out underflow steps and
// decided bits, each decided bit followed by the pending bits it releases,
// and it holds while the output stalls. Finally the count table is walked
// from the symbol upward, or the whole table when the total has reached
// 0x3fff and counts are halved. Symbols outside the alphabet are dropped on
// input. After reset all SYMBOLS + 1 entries of the count table are
// initialized, during which no transaction is accepted. A finish transaction
// flushes the stream; reset is expected after it.
// Depends on aae_pkg, aae_if, aae_front, aae_fifo and aae_back.
`timescale 1ns / 1ps

module adaptive_arithmetic_encoder
  import aae_pkg::*;
#(
  parameter int SYMBOLS       = 256,
  parameter int PENDING_LIMIT = 480
) (
  input  logic clk_i,
  input  logic rst_ni,
  aae_in_if.sink    in_i,
  aae_out_if.source out_o
);

  logic push, full, pop, avail, back_ready;
  op_t  push_op, head;

  aae_front #(
    .SYMBOLS (SYMBOLS)
  ) u_front (
    .in_i      (in_i),
    .ready_i   (back_ready),
    .full_i    (full),
    .push_o    (push),
    .push_op_o (push_op)
  );

  aae_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .avail_o   (avail),
    .head_o    (head)
  );

  aae_back #(
    .SYMBOLS       (SYMBOLS),
    .PENDING_LIMIT (PENDING_LIMIT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_avail_i (avail),
    .op_i       (head),
    .pop_o      (pop),
    .ready_o    (back_ready),
    .out_o      (out_o)
  );

endmodule

// ===== rtl/aae_fifo.sv =====
// Two-entry operation queue between the front and the back end.
// Depends on aae_pkg.
`timescale 1ns / 1ps

module aae_fifo
  import aae_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output op_t  head_o
);

  op_t        entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_op_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign head_o  = entry_q[rptr_q];

endmodule

// ===== rtl/aae_front.sv =====
// Front end: accepts input transactions and sorts out symbols outside the alphabet.
// Depends on aae_pkg and aae_if.
`timescale 1ns / 1ps

module aae_front
  import aae_pkg::*;
#(
  parameter int SYMBOLS = 256
) (
  aae_in_if.sink in_i,
  input  logic   ready_i,
  input  logic   full_i,
  output logic   push_o,
  output op_t    push_op_o
);

  logic is_finish;
  logic sym_ok;

  assign is_finish = (in_i.command == CMD_FINISH);
  assign sym_ok    = (32'(in_i.symbol) < 32'(SYMBOLS));

  assign in_i.ready = ready_i && !full_i;

  // An encode of a symbol outside the alphabet is taken and dropped here.
  assign push_o           = in_i.valid && in_i.ready && (is_finish || sym_ok);
  assign push_op_o.finish = is_finish;
  assign push_op_o.symbol = in_i.symbol;

endmodule

// ===== rtl/aae_div.sv =====
// Restoring divider, one quotient bit per cycle, for the interval scaling.
// Depends on aae_pkg.
`timescale 1ns / 1ps

module aae_div
  import aae_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [SPAN_W-1:0] quot_o
);

  localparam int CW = $clog2(PROD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PROD_W-1:0] dq_q, dq_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W:0]    trial;
  logic              ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, dq_q[PROD_W-1]};
    ge     = (trial >= {1'b0, div_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
      dq_d  = {dq_q[PROD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q[SPAN_W-1:0];

endmodule

// ===== rtl/aae_back.sv =====
// Back end: interval narrowing, renormalization, bit packing and count table upkeep.
// Depends on aae_pkg, aae_if and aae_div.
`timescale 1ns / 1ps

module aae_back
  import aae_pkg::*;
#(
  parameter int SYMBOLS       = 256,
  parameter int PENDING_LIMIT = 480
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_avail_i,
  input  op_t  op_i,
  output logic pop_o,
  output logic ready_o,
  aae_out_if.source out_o
);

  localparam int AW = $clog2(SYMBOLS + 1);
  localparam int SW = (AW > 8) ? AW : 8;
  localparam logic [PEND_W-1:0] PLIM = PEND_W'(PENDING_LIMIT);

  // Count table memory.
  logic [CNT_W-1:0] mem_q [SYMBOLS + 1];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [CNT_W-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  back_state_e       state_q, state_d;
  logic [CODE_W-1:0] low_q, low_d, high_q, high_d;
  logic [CODE_W-1:0] dl_q, dl_d, dh_q, dh_d;
  logic [PEND_W-1:0] pend_q, pend_d, dp_q, dp_d;
  logic [7:0]        acc_q, acc_d;
  logic [2:0]        pos_q, pos_d;
  logic              flag_q, flag_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [AW-1:0]     sym_q, sym_d;
  logic              fin_q, fin_d;
  logic              bit_q, bit_d;
  logic [GUARD_W-1:0] guard_q, guard_d;
  logic [CNT_W-1:0]  clo_q, clo_d, chi_q, chi_d;
  logic              sel_q, sel_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [SPAN_W-1:0] qhi_q, qhi_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]  h_q, h_d, prev_q, prev_d;
  logic              halve_q, halve_d;
  logic              hold_v_q, hold_v_d;
  logic [7:0]        hold_q, hold_d;
  logic              out_v_q, out_v_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_sat_q, out_sat_d;

  logic              div_start, div_done;
  logic [SPAN_W-1:0] quot;
  logic [CNT_W-1:0]  divisor;
  logic [SPAN_W-1:0] span;
  logic [SW-1:0]     op_sym;

  logic              out_free;
  logic              do_bit, bit_val, byte_full, can_bit;
  logic [7:0]        bit_acc;
  logic              push_hold;
  logic [7:0]        push_byte;
  renorm_e           cls_real, cls_dry;
  logic [CNT_W-1:0]  old_cnt, diff_cnt, hnew, upd_val;

  function automatic renorm_e classify(input logic [CODE_W-1:0] l, input logic [CODE_W-1:0] h);
    renorm_e c;
    if (h < QTR2) begin
      c = RN_ZERO;
    end else if (l >= QTR2) begin
      c = RN_ONE;
    end else if (l >= QTR1 && h < QTR3) begin
      c = RN_MID;
    end else begin
      c = RN_NONE;
    end
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] shift_low(input renorm_e c, input logic [CODE_W-1:0] l);
    logic [CODE_W-1:0] t;
    case (c)
      RN_ONE:  t = l - QTR2;
      RN_MID:  t = l - QTR1;
      default: t = l;
    endcase
    return {t[CODE_W-2:0], 1'b0};
  endfunction

  function automatic logic [CODE_W-1:0] shift_high(input renorm_e c, input logic [CODE_W-1:0] h);
    logic [CODE_W-1:0] t;
    case (c)
      RN_ONE:  t = h - QTR2;
      RN_MID:  t = h - QTR1;
      default: t = h;
    endcase
    return {t[CODE_W-2:0], 1'b1};
  endfunction

  assign span     = {1'b0, high_q} - {1'b0, low_q} + SPAN_W'(1);
  assign divisor  = (total_q == '0) ? CNT_W'(1) : total_q;
  assign op_sym   = SW'(op_i.symbol);
  assign out_free = !out_v_q || out_o.ready;
  assign cls_real = classify(low_q, high_q);
  assign cls_dry  = classify(dl_q, dh_q);

  assign bit_acc   = acc_q | (8'(bit_val) << pos_q);
  assign byte_full = (pos_q == 3'd7);
  assign can_bit   = !byte_full || !hold_v_q || out_free;

  assign old_cnt  = rdata_q;
  assign diff_cnt = old_cnt - prev_q;
  assign hnew     = h_q + CNT_W'(({1'b0, diff_cnt} + 15'd1) >> 1);
  assign upd_val  = (halve_q ? hnew : old_cnt) + CNT_W'(idx_q >= sym_q);

  aae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d    = state_q;
    low_d      = low_q;
    high_d     = high_q;
    dl_d       = dl_q;
    dh_d       = dh_q;
    pend_d     = pend_q;
    dp_d       = dp_q;
    acc_d      = acc_q;
    pos_d      = pos_q;
    flag_d     = flag_q;
    total_d    = total_q;
    sym_d      = sym_q;
    fin_d      = fin_q;
    bit_d      = bit_q;
    guard_d    = guard_q;
    clo_d      = clo_q;
    chi_d      = chi_q;
    sel_d      = sel_q;
    prod_d     = prod_q;
    qhi_d      = qhi_q;
    idx_d      = idx_q;
    h_d        = h_q;
    prev_d     = prev_q;
    halve_d    = halve_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    out_v_d    = out_v_q && !out_o.ready;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_sat_d  = out_sat_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = CNT_W'(idx_q);
    mem_raddr  = sym_q;
    div_start  = 1'b0;
    pop_o      = 1'b0;
    do_bit     = 1'b0;
    bit_val    = bit_q;
    push_hold  = 1'b0;
    push_byte  = acc_q;

    case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == AW'(SYMBOLS)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_avail_i) begin
          pop_o     = 1'b1;
          fin_d     = op_i.finish;
          sym_d     = op_sym[AW-1:0];
          mem_raddr = op_sym[AW-1:0];
          state_d   = op_i.finish ? S_FIN : S_RD1;
        end
      end
      S_RD1: begin
        clo_d     = rdata_q;
        mem_raddr = sym_q + 1'b1;
        state_d   = S_RD2;
      end
      S_RD2: begin
        chi_d   = rdata_q;
        sel_d   = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = PROD_W'(span) * PROD_W'(sel_q ? clo_q : chi_q);
        state_d = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          if (!sel_q) begin
            qhi_d   = quot;
            sel_d   = 1'b1;
            state_d = S_MUL;
          end else begin
            high_d  = CODE_W'({1'b0, low_q} + qhi_q - SPAN_W'(1));
            low_d   = CODE_W'({1'b0, low_q} + quot);
            dl_d    = CODE_W'({1'b0, low_q} + quot);
            dh_d    = CODE_W'({1'b0, low_q} + qhi_q - SPAN_W'(1));
            dp_d    = pend_q;
            guard_d = '0;
            state_d = S_DRY;
          end
        end
      end
      // Trial pass over the renormalization: only the pending count is tracked,
      // so the saturation flag of this transaction is final before any byte leaves.
      S_DRY: begin
        if (cls_dry == RN_NONE) begin
          guard_d = '0;
          state_d = S_REAL;
        end else begin
          dl_d = shift_low(cls_dry, dl_q);
          dh_d = shift_high(cls_dry, dh_q);
          if (cls_dry == RN_MID) begin
            if (dp_q >= PLIM) begin
              flag_d = 1'b1;
            end else begin
              dp_d = dp_q + 1'b1;
            end
          end else begin
            dp_d = '0;
          end
          if (guard_q == '1) begin
            guard_d = '0;
            state_d = S_REAL;
          end else begin
            guard_d = guard_q + 1'b1;
          end
        end
      end
      S_REAL: begin
        case (cls_real)
          RN_ZERO, RN_ONE: begin
            bit_d   = (cls_real == RN_ONE);
            state_d = S_PUTBIT;
          end
          RN_MID: begin
            if (pend_q >= PLIM) begin
              flag_d = 1'b1;
            end else begin
              pend_d = pend_q + 1'b1;
            end
            low_d  = shift_low(cls_real, low_q);
            high_d = shift_high(cls_real, high_q);
            if (guard_q == '1) begin
              state_d = S_UPD_SETUP;
            end else begin
              guard_d = guard_q + 1'b1;
            end
          end
          default: state_d = S_UPD_SETUP;
        endcase
      end
      S_PUTBIT: begin
        do_bit  = 1'b1;
        bit_val = bit_q;
        if (can_bit) begin
          state_d = S_PUTPEND;
        end
      end
      S_PUTPEND: begin
        if (pend_q == '0) begin
          if (fin_q) begin
            state_d = S_FLUSH;
          end else begin
            low_d  = shift_low(cls_real, low_q);
            high_d = shift_high(cls_real, high_q);
            if (guard_q == '1) begin
              state_d = S_UPD_SETUP;
            end else begin
              guard_d = guard_q + 1'b1;
              state_d = S_REAL;
            end
          end
        end else begin
          do_bit  = 1'b1;
          bit_val = ~bit_q;
          if (can_bit) begin
            pend_d = pend_q - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (pend_q >= PLIM) begin
          flag_d = 1'b1;
        end else begin
          pend_d = pend_q + 1'b1;
        end
        bit_d   = (low_q >= QTR1);
        state_d = S_PUTBIT;
      end
      // The partial byte goes out as it stands; accumulator and position stay.
      S_FLUSH: begin
        if (!hold_v_q || out_free) begin
          push_hold = 1'b1;
          push_byte = acc_q;
          state_d   = S_DONE;
        end
      end
      S_UPD_SETUP: begin
        halve_d = (total_q == COUNT_MAX);
        idx_d   = (total_q == COUNT_MAX) ? '0 : sym_q;
        h_d     = '0;
        prev_d  = '0;
        state_d = S_UPD_RD;
      end
      S_UPD_RD: begin
        mem_raddr = idx_q + 1'b1;
        state_d   = S_UPD_WR;
      end
      // When rescaling, h_q carries the new running sum and prev_q the old one.
      S_UPD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q + 1'b1;
        mem_wdata = upd_val;
        prev_d    = old_cnt;
        h_d       = hnew;
        if (idx_q == AW'(SYMBOLS - 1)) begin
          total_d = upd_val;
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_UPD_RD;
        end
      end
      S_DONE: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_byte_d = hold_q;
          out_last_d = 1'b1;
          out_sat_d  = flag_q;
          hold_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (do_bit && can_bit) begin
      if (byte_full) begin
        push_hold = 1'b1;
        push_byte = bit_acc;
        acc_d     = '0;
        pos_d     = '0;
      end else begin
        acc_d = bit_acc;
        pos_d = pos_q + 1'b1;
      end
    end

    // One finished byte waits in the hold register until it is known whether
    // it is the last one of the transaction.
    if (push_hold) begin
      if (hold_v_q) begin
        out_v_d    = 1'b1;
        out_byte_d = hold_q;
        out_last_d = 1'b0;
        out_sat_d  = flag_q;
      end
      hold_v_d = 1'b1;
      hold_d   = push_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      low_q    <= '0;
      high_q   <= '1;
      pend_q   <= '0;
      acc_q    <= '0;
      pos_q    <= '0;
      flag_q   <= 1'b0;
      total_q  <= CNT_W'(SYMBOLS);
      fin_q    <= 1'b0;
      guard_q  <= '0;
      sel_q    <= 1'b0;
      idx_q    <= '0;
      halve_q  <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      low_q    <= low_d;
      high_q   <= high_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      pos_q    <= pos_d;
      flag_q   <= flag_d;
      total_q  <= total_d;
      fin_q    <= fin_d;
      guard_q  <= guard_d;
      sel_q    <= sel_d;
      idx_q    <= idx_d;
      halve_q  <= halve_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q       <= dl_d;
    dh_q       <= dh_d;
    dp_q       <= dp_d;
    sym_q      <= sym_d;
    bit_q      <= bit_d;
    clo_q      <= clo_d;
    chi_q      <= chi_d;
    prod_q     <= prod_d;
    qhi_q      <= qhi_d;
    h_q        <= h_d;
    prev_q     <= prev_d;
    hold_q     <= hold_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_sat_q  <= out_sat_d;
  end

  assign ready_o                 = (state_q != S_INIT);
  assign out_o.valid             = out_v_q;
  assign out_o.out_byte          = out_byte_q;
  assign out_o.last              = out_last_q;
  assign out_o.pending_saturated = out_sat_q;

endmodule
